FILE: rtl/core/sirp_pkg.sv
package sirp_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_CHARS_DEF  = 1023;
    localparam int CHARS_USED_W   = 10;
    localparam int STATUS_W       = 2;
    localparam int RADIX_W        = 6;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_BIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_B36  = 6'd36;
    localparam logic [RADIX_W-1:0] NOT_DIGIT  = 6'd36;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_START    = 2'd1,
        ST_DIGIT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGNED = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    function automatic logic [RADIX_W-1:0] digit_of(input logic [7:0] c);
        logic [RADIX_W-1:0] d;
        d = NOT_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = RADIX_W'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = RADIX_W'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = RADIX_W'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

FILE: rtl/core/sigil_radix_integer_parser.sv
// multi-radix integer literal parser
// input stream: one character per request, tdata[7:0] = ch, tlast = last
// of the available span. a literal is an optional '-', an optional sigil
// ('#' decimal, '$' hex, '%' binary, none = base 36) and digits with '_'
// as separator. it ends at a non-alphanumeric byte (not counted), after
// the character with tlast, or at the length limit.
// output stream: one request per literal, tdata holds value, chars_used
// and status (0 ok, 1 bad start or no body, 2 bad digit, 3 overflow).
// a character is held in the input register and its result is loaded
// into the output register once the output is free, raising tvalid.
// throughput: one character per cycle unless one that ends a literal
// waits on a stalled receiver; the per-character multiply-add by the
// radix is the path that sets the clock.
// reset clears the parser state and the valid flags of both registers, ready for a new
// literal. when the receiver stalls, the result is held and characters
// that give no result keep flowing; one that ends a literal waits.
module sigil_radix_integer_parser #(
    parameter int VALUE_BITS = sirp_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = sirp_pkg::MAX_CHARS_DEF,
    parameter int OUT_W      = ((VALUE_BITS + sirp_pkg::CHARS_USED_W
                                 + sirp_pkg::STATUS_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] ch
    input  logic             i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // value, chars_used, status, zero pad
);
    import sirp_pkg::*;

    localparam int ACC_W  = VALUE_BITS - 1;
    localparam int PROD_W = ACC_W + RADIX_W + 1;
    localparam int CNT_RAW = $clog2(MAX_CHARS + 1);
    localparam int CNT_W  = (CNT_RAW > CHARS_USED_W) ? CNT_RAW : CHARS_USED_W;

    // input register
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_last;

    // parser state
    t_phase             r_phase,    n_phase;
    logic               r_negative, n_negative;
    logic [RADIX_W-1:0] r_radix,    n_radix;
    logic [ACC_W-1:0]   r_acc,      n_acc;
    logic [CNT_W-1:0]   r_count,    n_count;
    logic               r_body,     n_body;

    // result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic               s_err;
    t_status            s_err_code;
    logic               s_consume;
    logic               s_term;
    logic               s_emit;
    logic               s_end;
    t_phase             s_phase_post;
    logic               s_neg_post;
    logic [RADIX_W-1:0] s_radix_post;
    logic [ACC_W-1:0]   s_acc_post;
    logic [CNT_W-1:0]   s_cnt_post;
    logic               s_body_post;
    logic [RADIX_W-1:0] s_digit;
    logic               s_is_digit;
    logic [PROD_W-1:0]  s_sum;
    logic               s_ovf;

    t_status            w_status;
    logic [VALUE_BITS-1:0] w_value;
    logic [OUT_W-1:0]   w_word;
    logic               w_out_free;
    logic               w_adv;

    // character decode and state update of the current character
    always_comb begin
        s_digit      = digit_of(r_ch);
        s_is_digit   = (s_digit != NOT_DIGIT);
        s_sum        = PROD_W'(r_acc) * PROD_W'(r_radix) + PROD_W'(s_digit);
        s_ovf        = (s_sum[PROD_W-1:ACC_W] != '0);
        s_err        = 1'b0;
        s_err_code   = ST_OK;
        s_consume    = 1'b0;
        s_term       = 1'b0;
        s_phase_post = r_phase;
        s_neg_post   = r_negative;
        s_radix_post = r_radix;
        s_acc_post   = r_acc;
        s_body_post  = r_body;
        if (r_phase != PH_BODY) begin
            if (r_phase == PH_START && r_ch == CH_MINUS) begin
                s_neg_post   = 1'b1;
                s_phase_post = PH_SIGNED;
                s_consume    = 1'b1;
            end else if (r_ch == CH_HASH || r_ch == CH_DOLLAR || r_ch == CH_PCT) begin
                s_radix_post = (r_ch == CH_HASH) ? RADIX_DEC :
                               (r_ch == CH_DOLLAR) ? RADIX_HEX : RADIX_BIN;
                s_phase_post = PH_BODY;
                s_consume    = 1'b1;
            end else if (s_is_digit) begin
                s_radix_post = RADIX_B36;
                s_phase_post = PH_BODY;
                s_acc_post   = ACC_W'(s_digit);
                s_body_post  = 1'b1;
                s_consume    = 1'b1;
            end else begin
                s_err      = 1'b1;
                s_err_code = ST_START;
            end
        end else begin
            if (s_is_digit) begin
                if (s_digit >= r_radix || r_radix == '0) begin
                    s_err      = 1'b1;
                    s_err_code = ST_DIGIT;
                end else if (s_ovf) begin
                    s_err      = 1'b1;
                    s_err_code = ST_OVERFLOW;
                end else begin
                    s_acc_post  = s_sum[ACC_W-1:0];
                    s_body_post = 1'b1;
                    s_consume   = 1'b1;
                end
            end else if (r_ch == CH_UNDER) begin
                s_body_post = 1'b1;
                s_consume   = 1'b1;
            end else begin
                s_term = 1'b1;
            end
        end
        s_cnt_post = s_consume ? r_count + 1'b1 : r_count;
        s_end      = s_consume && (r_last || s_cnt_post >= CNT_W'(MAX_CHARS));
        s_emit     = s_err || s_term || s_end;
    end

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && (!s_emit || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_radix    = r_radix;
        n_acc      = r_acc;
        n_count    = r_count;
        n_body     = r_body;
        if (w_adv) begin
            if (s_emit) begin
                n_phase    = PH_START;
                n_negative = 1'b0;
                n_radix    = '0;
                n_acc      = '0;
                n_count    = '0;
                n_body     = 1'b0;
            end else begin
                n_phase    = s_phase_post;
                n_negative = s_neg_post;
                n_radix    = s_radix_post;
                n_acc      = s_acc_post;
                n_count    = s_cnt_post;
                n_body     = s_body_post;
            end
        end
    end

    // result word
    always_comb begin
        if (s_err) begin
            w_status = s_err_code;
        end else if (s_body_post) begin
            w_status = ST_OK;
        end else begin
            w_status = ST_START;
        end
        w_value = s_neg_post ? -{1'b0, s_acc_post} : {1'b0, s_acc_post};
        w_word  = '0;
        case (w_status)
            ST_OK: begin
                w_word[VALUE_BITS-1:0]              = w_value;
                w_word[VALUE_BITS +: CHARS_USED_W]  = s_cnt_post[CHARS_USED_W-1:0];
            end
            default: begin
                w_word[VALUE_BITS-1:0] = '0;
            end
        endcase
        w_word[VALUE_BITS + CHARS_USED_W +: STATUS_W] = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_START;
            r_negative  <= 1'b0;
            r_radix     <= '0;
            r_acc       <= '0;
            r_count     <= '0;
            r_body      <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= w_adv && s_emit;
            end
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_radix    <= n_radix;
            r_acc      <= n_acc;
            r_count    <= n_count;
            r_body     <= n_body;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_ch   <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
        if (w_out_free && w_adv && s_emit) begin
            r_out_data <= w_word;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sirp_pkg::*;

    localparam int OUT_W      = ((VALUE_BITS_DEF + CHARS_USED_W + STATUS_W + 7) / 8) * 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int ITEM_TARGET = 1650;
    localparam logic [63:0] MAG_MAX = (64'd1 << (VALUE_BITS_DEF - 1)) - 64'd1;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;
    } t_char_req;

    typedef struct {
        logic [31:0] value;
        logic [9:0]  used;
        t_status     status;
    } t_lit_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;     // [7:0] ch
    logic i_s_axis_tlast = 1'b0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;       // [31:0] value, [41:32] chars_used, [43:42] status

    sigil_radix_integer_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    t_char_req   char_q[$];
    t_lit_result expected_lits[$];
    int errors = 0;
    int chars_queued = 0;
    int chars_sent = 0;
    int lits_checked = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int cycles = 0;

    // parser state mirror
    t_phase             lit_phase = PH_START;
    logic               lit_neg = 1'b0;
    logic [RADIX_W-1:0] lit_radix = '0;
    logic [63:0]        lit_mag = '0;
    int                 lit_count = 0;
    logic               lit_body = 1'b0;

    function automatic logic [RADIX_W-1:0] char_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return RADIX_W'(c - "0");
        if (c >= "a" && c <= "z") return RADIX_W'(c - "a" + 8'd10);
        if (c >= "A" && c <= "Z") return RADIX_W'(c - "A" + 8'd10);
        return NOT_DIGIT;
    endfunction

    function automatic logic [7:0] digit_char(input int v, input bit upper);
        if (v < 10) return 8'("0" + v);
        return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    function automatic logic [7:0] pick_terminator();
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0) return 8'h00;
        do c = 8'($urandom_range(0, 255));
        while (char_digit(c) != NOT_DIGIT || c == CH_UNDER);
        return c;
    endfunction

    // advance the parser mirror by one character, queue the literal result if it closes
    task automatic literal_step(input logic [7:0] c, input logic lst);
        logic [RADIX_W-1:0] d;
        logic [63:0] neg_mag;
        bit done;
        t_status st;
        t_lit_result r;
        d = char_digit(c);
        done = 0;
        st = ST_OK;
        if (lit_phase != PH_BODY) begin
            if (lit_phase == PH_START && c == CH_MINUS) begin
                lit_neg = 1'b1;
                lit_phase = PH_SIGNED;
            end else if (c == CH_HASH || c == CH_DOLLAR || c == CH_PCT) begin
                lit_radix = (c == CH_HASH) ? RADIX_DEC : (c == CH_DOLLAR) ? RADIX_HEX : RADIX_BIN;
                lit_phase = PH_BODY;
            end else if (d != NOT_DIGIT) begin
                lit_radix = RADIX_B36;
                lit_phase = PH_BODY;
                lit_mag = 64'(d);
                lit_body = 1'b1;
            end else begin
                done = 1;
                st = ST_START;
            end
        end else begin
            if (d != NOT_DIGIT) begin
                if (d >= lit_radix) begin
                    done = 1;
                    st = ST_DIGIT;
                end else if (lit_mag > (MAG_MAX - 64'(d)) / 64'(lit_radix)) begin
                    done = 1;
                    st = ST_OVERFLOW;
                end else begin
                    lit_mag = lit_mag * 64'(lit_radix) + 64'(d);
                    lit_body = 1'b1;
                end
            end else if (c == CH_UNDER) begin
                lit_body = 1'b1;
            end else begin
                // terminator, not counted
                done = 1;
                st = lit_body ? ST_OK : ST_START;
            end
        end
        if (!done) begin
            lit_count++;
            if (lst || lit_count >= MAX_CHARS_DEF) begin
                done = 1;
                st = lit_body ? ST_OK : ST_START;
            end
        end
        if (done) begin
            r.status = st;
            r.value = '0;
            r.used = '0;
            if (st == ST_OK) begin
                neg_mag = -lit_mag;
                r.value = lit_neg ? neg_mag[31:0] : lit_mag[31:0];
                r.used = lit_count[9:0];
            end
            expected_lits.push_back(r);
            lit_phase = PH_START;
            lit_neg = 1'b0;
            lit_radix = '0;
            lit_mag = '0;
            lit_count = 0;
            lit_body = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic push_ch(input logic [7:0] c, input logic lst);
        t_char_req q;
        q.ch = c;
        q.last = lst;
        q.drain = 0;
        char_q.push_back(q);
        chars_queued++;
    endtask

    task automatic push_text(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++) push_ch(s[i], end_last && i == s.len() - 1);
    endtask

    task automatic push_drain();
        t_char_req q;
        q.ch = 8'h00;
        q.last = 1'b0;
        q.drain = 1;
        char_q.push_back(q);
    endtask

    // one random literal: well-formed, near the overflow boundary, bad digit, or noise
    task automatic gen_literal();
        int kind;
        int sel;
        int r;
        int ndig;
        longint mag;
        string s;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            if ($urandom_range(0, 2) == 0) push_ch(CH_MINUS, 1'b0);
            sel = $urandom_range(0, 3);
            r = (sel == 0) ? 36 : (sel == 1) ? 10 : (sel == 2) ? 16 : 2;
            if (sel == 1) push_ch(CH_HASH, 1'b0);
            if (sel == 2) push_ch(CH_DOLLAR, 1'b0);
            if (sel == 3) push_ch(CH_PCT, 1'b0);
            ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 8);
            if (sel == 0 && ndig == 0) ndig = 1;
            for (int i = 0; i < ndig; i++) begin
                if (!(sel == 0 && i == 0) && $urandom_range(0, 5) == 0) begin
                    push_ch(CH_UNDER, 1'b0);
                end else begin
                    push_ch(digit_char($urandom_range(0, r - 1), 1'($urandom_range(0, 1))),
                            1'b0);
                end
            end
            if ($urandom_range(0, 1) == 0 && char_q.size() > 0) begin
                char_q[$].last = 1'b1;
            end else begin
                push_ch(pick_terminator(), 1'($urandom_range(0, 1)));
            end
        end else if (kind < 72) begin
            mag = 64'h7FFF_FFFF + longint'($urandom_range(0, 6)) - 3;
            sel = $urandom_range(0, 2);
            if (sel == 0) s = $sformatf("#%0d", mag);
            else if (sel == 1) s = $sformatf("$%0h", mag);
            else s = $sformatf("%%%0b", mag);
            if ($urandom_range(0, 1) == 0) s = s.toupper();
            if ($urandom_range(0, 1) == 0) s = {"-", s};
            push_text(s, 1);
        end else if (kind < 85) begin
            if ($urandom_range(0, 3) == 0) push_ch(CH_MINUS, 1'b0);
            sel = $urandom_range(0, 2);
            r = (sel == 0) ? 10 : (sel == 1) ? 16 : 2;
            push_ch((sel == 0) ? CH_HASH : (sel == 1) ? CH_DOLLAR : CH_PCT, 1'b0);
            ndig = $urandom_range(0, 3);
            for (int i = 0; i < ndig; i++) push_ch(digit_char($urandom_range(0, r - 1), 0), 1'b0);
            push_ch(digit_char($urandom_range(r, 35), 1'($urandom_range(0, 1))),
                    1'($urandom_range(0, 1)));
        end else begin
            ndig = $urandom_range(1, 6);
            for (int i = 0; i < ndig; i++) begin
                push_ch(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // sender: bursts with random gaps, holds a request until taken
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : drive_chars
        t_char_req nx;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                literal_step(i_s_axis_tdata, i_s_axis_tlast);
                chars_sent++;
            end
            if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                if (char_q.size() > 0 && char_q[0].drain) begin
                    if (expected_lits.size() == 0) void'(char_q.pop_front());
                    i_s_axis_tvalid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    nx = char_q.pop_front();
                    i_s_axis_tdata <= nx.ch;
                    i_s_axis_tlast <= nx.last;
                    i_s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: modes of always ready, coin flips and long stalls
    int rdy_mode = 0;
    int mode_left = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rdy_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(64, 400);
        end else begin
            mode_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rdy_mode == 0) begin
            i_m_axis_tready <= 1'b1;
        end else if (rdy_mode == 1) begin
            i_m_axis_tready <= 1'($urandom_range(0, 1));
        end else begin
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 20);
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_lit_result e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_lits.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
            end else begin
                e = expected_lits.pop_front();
                if (o_m_axis_tdata[31:0] !== e.value)
                    report_mismatch($sformatf("value %h, want %h",
                                              o_m_axis_tdata[31:0], e.value));
                if (o_m_axis_tdata[41:32] !== e.used)
                    report_mismatch($sformatf("chars_used %0d, want %0d",
                                              o_m_axis_tdata[41:32], e.used));
                if (o_m_axis_tdata[43:42] !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_m_axis_tdata[43:42], e.status));
                if (o_m_axis_tdata[OUT_W-1:44] !== '0)
                    report_mismatch($sformatf("pad bits %h not zero",
                                              o_m_axis_tdata[OUT_W-1:44]));
                status_seen[e.status]++;
            end
            lits_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_lits.size());
            $display("** sigil_radix_integer_parser: FAILED **");
            $finish;
        end
    end

    initial begin
        bit mid_drain;
        int base_chars;
        mid_drain = 0;
        // directed: bad starts, no body, underscore-only body, bases, overflow
        push_text("-", 1);
        push_text("#", 1);
        push_ch(8'h00, 1'b0);
        push_ch(CH_UNDER, 1'b0);
        push_text("--", 0);
        push_ch(8'hFF, 1'b1);
        push_text("%2", 0);
        push_text("$_", 1);
        push_text("zZ ", 0);
        push_text("-#9", 1);
        push_text("$fF", 0);
        push_ch(8'h00, 1'b1);
        push_text("$80000000", 0);
        push_drain();
        // length limit: the underscores past the limit start new literals
        push_ch(CH_DOLLAR, 1'b0);
        for (int i = 0; i < 1100; i++) push_ch(CH_UNDER, i == 1099);
        push_drain();
        base_chars = chars_queued;
        while (chars_queued < ITEM_TARGET) begin
            gen_literal();
            if (!mid_drain && chars_queued > base_chars + (ITEM_TARGET - base_chars) / 2) begin
                push_ch(8'h00, 1'b0);
                push_drain();
                mid_drain = 1;
            end
        end
        // close any literal still open
        push_ch(8'h00, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() != 0 || i_s_axis_tvalid || expected_lits.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d characters sent, %0d literal results checked", chars_sent, lits_checked);
        $display("results by status: ok %0d, bad start %0d, bad digit %0d, overflow %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0) begin
            $display("** sigil_radix_integer_parser: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** sigil_radix_integer_parser: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sirp_pkg.sv
rtl/core/sigil_radix_integer_parser.sv
tb/tb_top.sv
